FILE: hdl/hdwm_pkg.sv
package hdwm_pkg;

  // Field widths fixed by the interface.
  localparam int AXIS_W    = 8;
  localparam int HEADING_W = 9;
  localparam int SPEED_W   = 16;
  localparam int DEAD_W    = 7;
  localparam int GAIN_W    = 6;

  // Doubled axis values span -256..254.
  localparam int DBL_W = AXIS_W + 1;

  // Configuration port geometry.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Degrees in a full turn; headings at or above this wrap.
  localparam int DEG_FULL = 360;

  // Unity gain in sixteenths, used for robot-centric mixing.
  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(16);

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_DEAD = 2'd1,
    REG_KNEE = 2'd2,
    REG_GAIN = 2'd3
  } reg_idx_t;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic                      mode;
    logic [DEAD_W-1:0]         deadzone;
    logic signed [AXIS_W-1:0]  knee;
    logic [GAIN_W-1:0]         gain;
  } cfg_t;

endpackage

FILE: hdl/hdwm_regs.sv
module hdwm_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hdwm_pkg::CFG_AW-1:0]   paddr,
  input  logic [hdwm_pkg::CFG_DW-1:0]   pwdata,
  output logic [hdwm_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output hdwm_pkg::cfg_t                cfg
);
  import hdwm_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t wr_idx;

  // A write completes in the access cycle; the port never waits.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_idx)
        REG_MODE: cfg_nxt.mode     = pwdata[0];
        REG_DEAD: cfg_nxt.deadzone = pwdata[DEAD_W-1:0];
        REG_KNEE: cfg_nxt.knee     = $signed(pwdata[AXIS_W-1:0]);
        REG_GAIN: cfg_nxt.gain     = pwdata[GAIN_W-1:0];
        default:  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= 1'b1;
      cfg_r.deadzone <= DEAD_W'(5);
      cfg_r.knee     <= AXIS_W'(40);
      cfg_r.gain     <= GAIN_W'(24);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read-back multiplexer.
  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(paddr[CFG_AW-1:2]))
      REG_MODE: prdata[0]          = cfg_r.mode;
      REG_DEAD: prdata[DEAD_W-1:0] = cfg_r.deadzone;
      REG_KNEE: prdata[AXIS_W-1:0] = cfg_r.knee;
      REG_GAIN: prdata[GAIN_W-1:0] = cfg_r.gain;
      default:  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

  // A knee write lands in the register on the following cycle.
  a_knee_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && wr_idx == REG_KNEE) |=> (cfg_r.knee == $past(pwdata[AXIS_W-1:0])))
    else $error("knee register does not hold the written word");

endmodule

FILE: hdl/hdwm_trig_rom.sv
module hdwm_trig_rom #(
  parameter int TRIG_FRAC_BITS = 15,
  parameter int ANGLE_STEPS    = 360
) (
  input  logic                               clk,
  input  logic [hdwm_pkg::HEADING_W-1:0]     heading,
  output logic signed [TRIG_FRAC_BITS+1:0]   sin_r,
  output logic signed [TRIG_FRAC_BITS+1:0]   cos_r
);
  import hdwm_pkg::*;

  localparam int TW       = TRIG_FRAC_BITS + 2;
  localparam int HEADINGS = 2 ** HEADING_W;
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

  // Round a Q30 value to the table precision, half up, clamped at zero.
  function automatic longint to_q(input longint v);
    longint c;
    c = (v < 0) ? 64'sd0 : v;
    return (c + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
  endfunction

  // Sine or cosine for one whole-degree heading, evaluated at elaboration.
  // The angle is folded into the first quadrant and expanded as a Taylor
  // series in Q30 with every product truncated.
  function automatic logic signed [TW-1:0] trig_val(input int hd, input logic want_sin);
    longint unsigned idx;
    longint unsigned quad;
    longint unsigned rem;
    longint unsigned th;
    longint unsigned t2;
    longint unsigned term;
    longint          sn;
    longint          cs;
    longint          sq;
    longint          cq;
    longint          res;
    idx  = ((longint'(hd) * ANGLE_STEPS + 180) / 360) % ANGLE_STEPS;
    quad = (idx * 4) / ANGLE_STEPS;
    rem  = (idx * 4) % ANGLE_STEPS;
    th   = rem * Q30_HALF_PI / ANGLE_STEPS;
    t2   = (th * th) >> 30;
    // Sine series: odd powers.
    term = th;
    sn   = longint'(th);
    term = ((term * t2) >> 30) / 6;   sn = sn - longint'(term);
    term = ((term * t2) >> 30) / 20;  sn = sn + longint'(term);
    term = ((term * t2) >> 30) / 42;  sn = sn - longint'(term);
    term = ((term * t2) >> 30) / 72;  sn = sn + longint'(term);
    term = ((term * t2) >> 30) / 110; sn = sn - longint'(term);
    term = ((term * t2) >> 30) / 156; sn = sn + longint'(term);
    // Cosine series: even powers.
    term = Q30_ONE;
    cs   = longint'(Q30_ONE);
    term = ((term * t2) >> 30) / 2;   cs = cs - longint'(term);
    term = ((term * t2) >> 30) / 12;  cs = cs + longint'(term);
    term = ((term * t2) >> 30) / 30;  cs = cs - longint'(term);
    term = ((term * t2) >> 30) / 56;  cs = cs + longint'(term);
    term = ((term * t2) >> 30) / 90;  cs = cs - longint'(term);
    term = ((term * t2) >> 30) / 132; cs = cs + longint'(term);
    sq = to_q(sn);
    cq = to_q(cs);
    // Quadrant unfolding.
    case (quad[1:0])
      2'd0:    res = want_sin ? sq : cq;
      2'd1:    res = want_sin ? cq : -sq;
      2'd2:    res = want_sin ? -sq : -cq;
      default: res = want_sin ? -cq : sq;
    endcase
    return res[TW-1:0];
  endfunction

  logic signed [TW-1:0] sin_tbl [HEADINGS];
  logic signed [TW-1:0] cos_tbl [HEADINGS];

  // One table entry per raw heading code; codes past a full turn wrap.
  for (genvar h = 0; h < HEADINGS; h++) begin : g_tbl
    localparam int HD = h % DEG_FULL;
    assign sin_tbl[h] = trig_val(HD, 1'b1);
    assign cos_tbl[h] = trig_val(HD, 1'b0);
  end

  // Registered table read.
  always_ff @(posedge clk) begin
    sin_r <= sin_tbl[heading];
    cos_r <= cos_tbl[heading];
  end

endmodule

FILE: hdl/hdwm_axis.sv
module hdwm_axis (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  hdwm_pkg::cfg_t                      cfg,
  input  logic signed [hdwm_pkg::AXIS_W-1:0]  strafe_axis,
  input  logic signed [hdwm_pkg::AXIS_W-1:0]  forward_axis,
  input  logic signed [hdwm_pkg::AXIS_W-1:0]  turn_axis,
  output logic                                v1_r,
  output logic                                mode1_r,
  output logic signed [hdwm_pkg::DBL_W-1:0]   x_r,
  output logic signed [hdwm_pkg::DBL_W-1:0]   y_r,
  output logic signed [hdwm_pkg::DBL_W-1:0]   t_r
);
  import hdwm_pkg::*;

  // Multiply by 171 and shift by 9 gives floor(n/3) for n below 512.
  localparam int DIV3_MUL   = 171;
  localparam int DIV3_SHIFT = 9;

  logic [AXIS_W-1:0]       mag_s;
  logic [AXIS_W-1:0]       mag_f;
  logic [AXIS_W-1:0]       mag_t;
  logic signed [DBL_W-1:0] dbl_s;
  logic signed [DBL_W-1:0] dbl_f;
  logic signed [DBL_W-1:0] dbl_t;
  logic [DBL_W-1:0]        dbl_t_mag;
  logic [DBL_W+7:0]        div_prod;
  logic [DBL_W-1:0]        third;
  logic signed [DBL_W-1:0] scaled_t;
  logic signed [DBL_W-1:0] x_nxt;
  logic signed [DBL_W-1:0] y_nxt;
  logic signed [DBL_W-1:0] t_nxt;

  // Raw magnitudes for the deadzone test; -128 maps to 128.
  assign mag_s = strafe_axis[AXIS_W-1]  ? AXIS_W'(-strafe_axis)  : strafe_axis;
  assign mag_f = forward_axis[AXIS_W-1] ? AXIS_W'(-forward_axis) : forward_axis;
  assign mag_t = turn_axis[AXIS_W-1]    ? AXIS_W'(-turn_axis)    : turn_axis;

  assign dbl_s = DBL_W'(strafe_axis) <<< 1;
  assign dbl_f = DBL_W'(forward_axis) <<< 1;
  assign dbl_t = DBL_W'(turn_axis) <<< 1;

  // One third of the doubled turn axis, truncated toward zero, then doubled.
  assign dbl_t_mag = dbl_t[DBL_W-1] ? DBL_W'(-dbl_t) : DBL_W'(dbl_t);
  assign div_prod  = (DBL_W+8)'(dbl_t_mag) * (DBL_W+8)'(DIV3_MUL);
  assign third     = DBL_W'(div_prod >> DIV3_SHIFT);
  always_comb begin
    if (dbl_t[DBL_W-1]) begin
      scaled_t = -$signed(DBL_W'(third << 1));
    end else begin
      scaled_t = $signed(DBL_W'(third << 1));
    end
  end

  // Knee selection and deadzone.
  always_comb begin
    x_nxt = (mag_s < AXIS_W'(cfg.deadzone)) ? '0 : dbl_s;
    y_nxt = (mag_f < AXIS_W'(cfg.deadzone)) ? '0 : dbl_f;
    if (mag_t < AXIS_W'(cfg.deadzone)) begin
      t_nxt = '0;
    end else if (turn_axis <= cfg.knee) begin
      t_nxt = scaled_t;
    end else begin
      t_nxt = dbl_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    mode1_r <= cfg.mode;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    t_r     <= t_nxt;
  end

endmodule

FILE: hdl/hdwm_mix.sv
module hdwm_mix #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 v1,
  input  logic                                 mode1,
  input  logic signed [hdwm_pkg::DBL_W-1:0]    x,
  input  logic signed [hdwm_pkg::DBL_W-1:0]    y,
  input  logic signed [hdwm_pkg::DBL_W-1:0]    t,
  input  logic signed [TRIG_FRAC_BITS+1:0]     sin_q,
  input  logic signed [TRIG_FRAC_BITS+1:0]     cos_q,
  input  logic [hdwm_pkg::GAIN_W-1:0]          gain,
  output logic                                 out_valid_r,
  output logic signed [hdwm_pkg::SPEED_W-1:0]  lf_r,
  output logic signed [hdwm_pkg::SPEED_W-1:0]  lb_r,
  output logic signed [hdwm_pkg::SPEED_W-1:0]  rf_r,
  output logic signed [hdwm_pkg::SPEED_W-1:0]  rb_r
);
  import hdwm_pkg::*;

  localparam int F   = TRIG_FRAC_BITS;
  localparam int TW  = F + 2;
  localparam int RW  = F + DBL_W + 2;   // rotated component
  localparam int AW  = RW + 1;          // sum or difference of components
  localparam int WW  = AW + GAIN_W + 2; // gained wheel value with turn added
  localparam int QW  = WW - F;          // wheel value in 1/16 rpm
  localparam logic signed [TW-1:0] Q_ONE = TW'(1) <<< F;
  localparam logic signed [WW-1:0] RND   = (WW'(1) <<< F) - WW'(1);
  localparam logic signed [QW-1:0] S_MAX = QW'(32767);
  localparam logic signed [QW-1:0] S_MIN = -QW'(32768);

  // Drop the fraction with truncation toward zero, then clamp to 16 bits.
  function automatic logic signed [SPEED_W-1:0] scale_sat(input logic signed [WW-1:0] w);
    logic signed [WW-1:0] b;
    logic signed [QW-1:0] q;
    b = w + (w[WW-1] ? RND : WW'(0));
    q = $signed(b[WW-1:F]);
    if (q > S_MAX) begin
      return SPEED_W'(S_MAX);
    end else if (q < S_MIN) begin
      return SPEED_W'(S_MIN);
    end
    return q[SPEED_W-1:0];
  endfunction

  // Stage two: rotation. Robot-centric mode rotates by zero degrees.
  logic signed [TW-1:0]    c_sel;
  logic signed [TW-1:0]    s_sel;
  logic signed [RW-1:0]    xr_nxt;
  logic signed [RW-1:0]    yr_nxt;
  logic signed [RW-1:0]    xr_r;
  logic signed [RW-1:0]    yr_r;
  logic signed [DBL_W-1:0] t2_r;
  logic                    mode2_r;
  logic                    v2_r;

  assign c_sel  = mode1 ? cos_q : Q_ONE;
  assign s_sel  = mode1 ? sin_q : '0;
  assign xr_nxt = RW'(x) * RW'(c_sel) - RW'(y) * RW'(s_sel);
  assign yr_nxt = RW'(x) * RW'(s_sel) + RW'(y) * RW'(c_sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1;
    end
  end

  always_ff @(posedge clk) begin
    xr_r    <= xr_nxt;
    yr_r    <= yr_nxt;
    t2_r    <= t;
    mode2_r <= mode1;
  end

  // Stage three: gain, turn mix and output scaling.
  logic [GAIN_W-1:0]       g_sel;
  logic signed [AW-1:0]    sum_a;
  logic signed [AW-1:0]    sum_b;
  logic signed [WW-1:0]    prod_a;
  logic signed [WW-1:0]    prod_b;
  logic signed [WW-1:0]    tq;

  assign g_sel  = mode2_r ? gain : GAIN_UNITY;
  assign sum_a  = AW'(yr_r) + AW'(xr_r);
  assign sum_b  = AW'(yr_r) - AW'(xr_r);
  assign prod_a = WW'(sum_a) * $signed(WW'(g_sel));
  assign prod_b = WW'(sum_b) * $signed(WW'(g_sel));
  assign tq     = WW'(t2_r) <<< (F + 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    lf_r <= scale_sat(prod_a + tq);
    lb_r <= scale_sat(prod_b + tq);
    rf_r <= scale_sat(prod_b - tq);
    rb_r <= scale_sat(prod_a - tq);
  end

  // Every word entering the mixer comes out through the rotation and output registers, and no strobe comes without one.
  a_stage2: assert property (@(posedge clk) disable iff (!rst_n)
    v1 |=> v2_r)
    else $error("rotation stage dropped a word");

  a_stage3: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |=> out_valid_r)
    else $error("output stage dropped a word");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    (!v1 ##1 !v2_r) |=> !out_valid_r)
    else $error("result strobe without an input word");

endmodule

FILE: hdl/holonomic_drive_wheel_mixer_core.sv
// Pipeline: a word accepted at a clock edge goes through the axis and table register, then
// the rotation register, then the output register, which raises its result strobe.
// Throughput: one word per cycle; busy is never raised, and each result shows for one cycle.
// The receiver cannot stall, so no result is ever held back.
// Synchronous active-low reset clears the valid pipeline and loads the register defaults.
module holonomic_drive_wheel_mixer_core #(
  parameter int TRIG_FRAC_BITS = 15,
  parameter int ANGLE_STEPS    = 360
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [hdwm_pkg::AXIS_W-1:0]   in_strafe_axis,
  input  logic signed [hdwm_pkg::AXIS_W-1:0]   in_forward_axis,
  input  logic signed [hdwm_pkg::AXIS_W-1:0]   in_turn_axis,
  input  logic [hdwm_pkg::HEADING_W-1:0]       in_heading,
  output logic                                 out_valid,
  output logic signed [hdwm_pkg::SPEED_W-1:0]  out_left_front_speed,
  output logic signed [hdwm_pkg::SPEED_W-1:0]  out_left_back_speed,
  output logic signed [hdwm_pkg::SPEED_W-1:0]  out_right_front_speed,
  output logic signed [hdwm_pkg::SPEED_W-1:0]  out_right_back_speed,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hdwm_pkg::CFG_AW-1:0]          paddr,
  input  logic [hdwm_pkg::CFG_DW-1:0]          pwdata,
  output logic [hdwm_pkg::CFG_DW-1:0]          prdata,
  output logic                                 pready
);
  import hdwm_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;

  cfg_t                    cfg;
  logic                    accept;
  logic                    v1;
  logic                    mode1;
  logic signed [DBL_W-1:0] x1;
  logic signed [DBL_W-1:0] y1;
  logic signed [DBL_W-1:0] t1;
  logic signed [TW-1:0]    sin1;
  logic signed [TW-1:0]    cos1;

  // The pipeline takes a word every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers.
  hdwm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Heading to sine and cosine.
  hdwm_trig_rom #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
    .ANGLE_STEPS    (ANGLE_STEPS)
  ) u_trig (
    .clk     (clk),
    .heading (in_heading),
    .sin_r   (sin1),
    .cos_r   (cos1)
  );

  // Axis conditioning: doubling, turn knee and deadzone.
  hdwm_axis u_axis (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .cfg          (cfg),
    .strafe_axis  (in_strafe_axis),
    .forward_axis (in_forward_axis),
    .turn_axis    (in_turn_axis),
    .v1_r         (v1),
    .mode1_r      (mode1),
    .x_r          (x1),
    .y_r          (y1),
    .t_r          (t1)
  );

  // Rotation, gain and wheel mixing.
  hdwm_mix #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_mix (
    .clk         (clk),
    .rst_n       (rst_n),
    .v1          (v1),
    .mode1       (mode1),
    .x           (x1),
    .y           (y1),
    .t           (t1),
    .sin_q       (sin1),
    .cos_q       (cos1),
    .gain        (cfg.gain),
    .out_valid_r (out_valid),
    .lf_r        (out_left_front_speed),
    .lb_r        (out_left_back_speed),
    .rf_r        (out_right_front_speed),
    .rb_r        (out_right_back_speed)
  );

endmodule

FILE: tb/hdwm_wheel_checker.sv
module hdwm_wheel_checker #(
  parameter int TRIG_FRAC_BITS = 15,
  parameter int ANGLE_STEPS    = 360
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic signed [hdwm_pkg::AXIS_W-1:0]   in_strafe_axis,
  input  logic signed [hdwm_pkg::AXIS_W-1:0]   in_forward_axis,
  input  logic signed [hdwm_pkg::AXIS_W-1:0]   in_turn_axis,
  input  logic [hdwm_pkg::HEADING_W-1:0]       in_heading,
  input  logic                                 out_valid,
  input  logic signed [hdwm_pkg::SPEED_W-1:0]  out_left_front_speed,
  input  logic signed [hdwm_pkg::SPEED_W-1:0]  out_left_back_speed,
  input  logic signed [hdwm_pkg::SPEED_W-1:0]  out_right_front_speed,
  input  logic signed [hdwm_pkg::SPEED_W-1:0]  out_right_back_speed,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hdwm_pkg::CFG_AW-1:0]          paddr,
  input  logic [hdwm_pkg::CFG_DW-1:0]          pwdata,
  input  logic                                 pready,
  output int                                   mismatch_count,
  output int                                   pending_words
);
  import hdwm_pkg::*;

  // Four wheel speeds in the order left front, left back, right front, right back.
  typedef logic [3:0][SPEED_W-1:0] wheel_set_t;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

  // Local copy of the register file, tracked from the configuration port.
  logic                     mode_q;
  logic [DEAD_W-1:0]        dead_q;
  logic signed [AXIS_W-1:0] knee_q;
  logic [GAIN_W-1:0]        gain_q;

  wheel_set_t expected_speeds[$];
  wheel_set_t seen_speeds;
  wheel_set_t want_speeds;
  string      wheel_name[4] = '{"left_front", "left_back", "right_front", "right_back"};

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // Alternating Taylor series in Q30 for an angle in the first quadrant.
  function automatic longint taylor_q30(input longint unsigned th, input longint unsigned first,
                                        input longint unsigned n0);
    longint unsigned th_sq;
    longint unsigned term;
    longint unsigned n;
    longint          acc;
    th_sq = (th * th) >> 30;
    term  = first;
    acc   = longint'(first);
    n     = n0;
    for (int k = 0; k < 6; k++) begin
      term = ((term * th_sq) >> 30) / ((n + 1) * (n + 2));
      n += 2;
      if (k % 2 == 1) acc += longint'(term);
      else acc -= longint'(term);
    end
    return acc;
  endfunction

  // Round a nonnegative Q30 value to the table format, half up.
  function automatic longint q30_to_table(input longint v);
    if (v < 0) v = 0;
    return (v + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
  endfunction

  // Sine and cosine of one table step, folded out of the first quadrant.
  function automatic void heading_trig(input longint unsigned idx, output longint sn,
                                       output longint cs);
    longint unsigned quad;
    longint unsigned rem_steps;
    longint unsigned th;
    longint          s;
    longint          c;
    quad      = (idx * 4) / ANGLE_STEPS;
    rem_steps = (idx * 4) % ANGLE_STEPS;
    th        = rem_steps * Q30_HALF_PI / ANGLE_STEPS;
    s = q30_to_table(taylor_q30(th, th, 1));
    c = q30_to_table(taylor_q30(th, Q30_ONE, 0));
    case (quad % 4)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic logic [SPEED_W-1:0] clamp_speed(input longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SPEED_W'(v);
  endfunction

  // Work out the four wheel speeds for one joystick word under the current registers.
  function automatic wheel_set_t mix_wheel_speeds(input logic signed [AXIS_W-1:0] strafe,
                                                  input logic signed [AXIS_W-1:0] fwd,
                                                  input logic signed [AXIS_W-1:0] turn,
                                                  input logic [HEADING_W-1:0] hdg);
    longint     rs, rf, rt, dz, x, y, t, hd, sn, cs, xr, yr, g, tq, one;
    longint     w[4];
    wheel_set_t res;
    rs = strafe;
    rf = fwd;
    rt = turn;
    dz = longint'(dead_q);
    hd = longint'(hdg) % DEG_FULL;
    x  = rs * 2;
    y  = rf * 2;
    t  = (rt <= longint'(knee_q)) ? (rt * 2) / 3 * 2 : rt * 2;
    if ((rs < 0 ? -rs : rs) < dz) x = 0;
    if ((rf < 0 ? -rf : rf) < dz) y = 0;
    if ((rt < 0 ? -rt : rt) < dz) t = 0;
    if (mode_q) begin
      heading_trig(longint'(((hd * ANGLE_STEPS + 180) / 360) % ANGLE_STEPS), sn, cs);
      one  = longint'(1) << TRIG_FRAC_BITS;
      g    = longint'(gain_q);
      tq   = t * 16 * one;
      xr   = x * cs - y * sn;
      yr   = x * sn + y * cs;
      w[0] = ((yr + xr) * g + tq) / one;
      w[1] = ((yr - xr) * g + tq) / one;
      w[2] = ((yr - xr) * g - tq) / one;
      w[3] = ((yr + xr) * g - tq) / one;
    end else begin
      w[0] = 16 * (y + x + t);
      w[1] = 16 * (y - x + t);
      w[2] = 16 * (y - x - t);
      w[3] = 16 * (y + x - t);
    end
    for (int i = 0; i < 4; i++) res[i] = clamp_speed(w[i]);
    return res;
  endfunction

  initial begin
    mismatch_count = 0;
    pending_words  = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q <= 1'b1;
      dead_q <= DEAD_W'(5);
      knee_q <= AXIS_W'(40);
      gain_q <= GAIN_W'(24);
      expected_speeds.delete();
    end else begin
      // Register writes complete on the access cycle.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_MODE: mode_q <= pwdata[0];
          REG_DEAD: dead_q <= pwdata[DEAD_W-1:0];
          REG_KNEE: knee_q <= pwdata[AXIS_W-1:0];
          REG_GAIN: gain_q <= pwdata[GAIN_W-1:0];
          default: ;
        endcase
      end

      // Check a result word against the oldest prediction.
      if (out_valid) begin
        seen_speeds = {out_right_back_speed, out_right_front_speed,
                       out_left_back_speed, out_left_front_speed};
        if (expected_speeds.size() == 0) begin
          report_mismatch("result with nothing pending, left_front", 0,
                          longint'($signed(out_left_front_speed)));
        end else begin
          want_speeds = expected_speeds.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (seen_speeds[i] !== want_speeds[i])
              report_mismatch(wheel_name[i], longint'($signed(want_speeds[i])),
                              longint'($signed(seen_speeds[i])));
          end
        end
      end

      // Predict every accepted joystick word.
      if (start && !busy)
        expected_speeds.push_back(mix_wheel_speeds(in_strafe_axis, in_forward_axis,
                                                   in_turn_axis, in_heading));
    end
    pending_words = expected_speeds.size();
  end

endmodule

FILE: tb/holonomic_drive_wheel_mixer_core_tb.sv
module holonomic_drive_wheel_mixer_core_tb;
  import hdwm_pkg::*;

  localparam int FRAC_BITS  = 15;
  localparam int STEP_COUNT = 360;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic signed [AXIS_W-1:0]    in_strafe_axis;
  logic signed [AXIS_W-1:0]    in_forward_axis;
  logic signed [AXIS_W-1:0]    in_turn_axis;
  logic [HEADING_W-1:0]        in_heading;
  logic                        out_valid;
  logic signed [SPEED_W-1:0]   out_left_front_speed;
  logic signed [SPEED_W-1:0]   out_left_back_speed;
  logic signed [SPEED_W-1:0]   out_right_front_speed;
  logic signed [SPEED_W-1:0]   out_right_back_speed;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [CFG_AW-1:0]           paddr;
  logic [CFG_DW-1:0]           pwdata;
  logic [CFG_DW-1:0]           prdata;
  logic                        pready;
  int                          mismatch_count;
  int                          pending_words;

  // Stimulus-side view of the deadzone and knee, used to aim axes at the edges.
  int cur_dead;
  int cur_knee;

  holonomic_drive_wheel_mixer_core #(
    .TRIG_FRAC_BITS(FRAC_BITS),
    .ANGLE_STEPS   (STEP_COUNT)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_strafe_axis       (in_strafe_axis),
    .in_forward_axis      (in_forward_axis),
    .in_turn_axis         (in_turn_axis),
    .in_heading           (in_heading),
    .out_valid            (out_valid),
    .out_left_front_speed (out_left_front_speed),
    .out_left_back_speed  (out_left_back_speed),
    .out_right_front_speed(out_right_front_speed),
    .out_right_back_speed (out_right_back_speed),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  hdwm_wheel_checker #(
    .TRIG_FRAC_BITS(FRAC_BITS),
    .ANGLE_STEPS   (STEP_COUNT)
  ) i_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_strafe_axis       (in_strafe_axis),
    .in_forward_axis      (in_forward_axis),
    .in_turn_axis         (in_turn_axis),
    .in_heading           (in_heading),
    .out_valid            (out_valid),
    .out_left_front_speed (out_left_front_speed),
    .out_left_back_speed  (out_left_back_speed),
    .out_right_front_speed(out_right_front_speed),
    .out_right_back_speed (out_right_back_speed),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .pready               (pready),
    .mismatch_count       (mismatch_count),
    .pending_words        (pending_words)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  // Present one joystick word and hold it until the block takes it.
  task automatic send_word(input int strafe, input int fwd, input int turn, input int hdg);
    start           <= 1'b1;
    in_strafe_axis  <= AXIS_W'(strafe);
    in_forward_axis <= AXIS_W'(fwd);
    in_turn_axis    <= AXIS_W'(turn);
    in_heading      <= HEADING_W'(hdg);
    do @(posedge clk); while (busy);
  endtask

  // Register write with a setup phase and an access phase; upper data bits carry noise the block must ignore.
  task automatic write_reg(input reg_idx_t idx, input int unsigned value, input int width);
    logic [CFG_DW-1:0] keep;
    keep    = (CFG_DW'(1) << width) - 1;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom() & ~keep) | (CFG_DW'(value) & keep);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input int mode, input int dead, input int knee, input int gain);
    write_reg(REG_MODE, mode, 1);
    write_reg(REG_DEAD, dead, DEAD_W);
    write_reg(REG_KNEE, knee, AXIS_W);
    write_reg(REG_GAIN, gain, GAIN_W);
    cur_dead = dead % 128;
    cur_knee = int'($signed(AXIS_W'(knee)));
  endtask

  // Let every predicted word come back before touching the registers again.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  function automatic int pick_axis();
    int sgn;
    sgn = ($urandom_range(0, 1) == 1) ? 1 : -1;
    case ($urandom_range(0, 9))
      0: return int'($urandom_range(0, 255));
      1: return sgn * (cur_dead - int'($urandom_range(0, 1)));
      2: return cur_knee + int'($urandom_range(0, 2)) - 1;
      default: return int'($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  function automatic int pick_heading();
    case ($urandom_range(0, 7))
      0: return int'($urandom_range(0, 511));
      1: return 90 * int'($urandom_range(0, 4)) + int'($urandom_range(0, 2)) - 1 + 1;
      default: return int'($urandom_range(0, 359));
    endcase
  endfunction

  // Random words in bursts, with random gaps and some back-to-back stretches.
  task automatic send_random(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = int'($urandom_range(1, 16));
      if (burst > left) burst = left;
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      for (int i = 0; i < burst; i++)
        send_word(pick_axis(), pick_axis(), pick_axis(), pick_heading());
      left -= burst;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    start           <= 1'b0;
    in_strafe_axis  <= '0;
    in_forward_axis <= '0;
    in_turn_axis    <= '0;
    in_heading      <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    rst_n           <= 1'b0;
    cur_dead = 5;
    cur_knee = 40;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset settings: axis extremes, deadzone and
    // knee edges, quadrant boundaries and headings that wrap past a full turn.
    send_word(0, 0, 0, 0);
    send_word(100, 0, 0, 0);
    send_word(0, 100, 0, 90);
    send_word(0, 0, 100, 180);
    send_word(0, 0, -100, 270);
    send_word(127, 127, 127, 359);
    send_word(-128, -128, -128, 360);
    send_word(-100, -100, -100, 511);
    send_word(4, -4, 5, 45);
    send_word(-5, 5, -4, 135);
    send_word(50, -50, 40, 225);
    send_word(50, 50, 41, 315);
    send_word(-1, 1, 39, 1);
    send_word(100, 100, -41, 89);
    send_word(-100, 100, -1, 91);
    send_word(100, -100, -42, 179);
    send_word(1, 1, 1, 181);
    send_word(-128, 127, -100, 269);
    send_word(127, -128, 100, 271);
    send_word(0, 0, -128, 400);
    send_word(85, -86, 7, 449);
    send_word(-86, 85, -7, 62);
    send_random(40);
    drain_results();

    // Register settings from robot-centric defaults through the extremes,
    // including values beyond the documented ranges.
    set_config(0, 5, 40, 24);
    send_random(55);
    drain_results();
    set_config(1, 0, -100, 48);
    send_random(55);
    drain_results();
    set_config(1, 100, 100, 0);
    send_random(50);
    drain_results();
    set_config(0, 127, -128, 63);
    send_random(50);
    drain_results();
    set_config(1, 3, 127, 63);
    send_random(60);
    drain_results();
    set_config(int'($urandom_range(0, 1)), int'($urandom_range(0, 20)),
               int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 48)));
    send_random(60);
    drain_results();

    // Quiet period covering the pipeline depth before the verdict.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/hdwm_pkg.sv
hdl/hdwm_regs.sv
hdl/hdwm_trig_rom.sv
hdl/hdwm_axis.sv
hdl/hdwm_mix.sv
hdl/holonomic_drive_wheel_mixer_core.sv
tb/hdwm_wheel_checker.sv
tb/holonomic_drive_wheel_mixer_core_tb.sv
